### sv/assert_macros.svh
// Assertion macros used by the RTL of the charge-current governor.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef ASSERT_OFF
// The condition must hold at every clock edge outside reset.
`define ASSERT_ALWAYS(label, clk, rst_n, cond) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond)) \
        else $error("assertion failed: condition does not hold");
// The consequent must hold in the cycle after the antecedent.
`define ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed: consequence missing in next cycle");
`else
`define ASSERT_ALWAYS(label, clk, rst_n, cond)
`define ASSERT_NEXT(label, clk, rst_n, ante, cons)
`endif

`endif

### sv/ccg_pkg.sv
// Types, codes and constants of the charge-current governor.
`timescale 1ns / 1ps

package ccg_pkg;

    localparam int CUR_W  = 22;
    localparam int VOLT_W = 23;
    localparam int TEMP_W = 12;
    localparam int NUM_ZONES = 5;

    typedef enum logic [1:0] {
        OP_BATTERY = 2'd0,
        OP_VOLTAGE = 2'd1,
        OP_CHARGER = 2'd2,
        OP_DISPLAY = 2'd3
    } op_t;

    typedef enum logic [2:0] {
        ZONE_COLD = 3'd0,
        ZONE_COOL = 3'd1,
        ZONE_GOOD = 3'd2,
        ZONE_WARM = 3'd3,
        ZONE_HOT  = 3'd4
    } zone_t;

    typedef enum logic [1:0] {
        REASON_DEFAULT = 2'd0,
        REASON_DISPLAY = 2'd1,
        REASON_STEP    = 2'd2,
        REASON_THERMAL = 2'd3
    } reason_t;

    // Register indexes on the configuration port.
    localparam logic [2:0] CFG_STEP_VOLTAGE    = 3'd0;
    localparam logic [2:0] CFG_STEP_CURRENT    = 3'd1;
    localparam logic [2:0] CFG_DISPLAY_CURRENT = 3'd2;
    localparam logic [2:0] CFG_DEFAULT_CURRENT = 3'd3;
    localparam logic [2:0] CFG_REDUCED_CURRENT = 3'd4;
    localparam logic [2:0] CFG_NORMAL_FLOAT    = 3'd5;
    localparam logic [2:0] CFG_LIMITED_FLOAT   = 3'd6;

    // Register values after reset.
    localparam logic [VOLT_W-1:0] RST_STEP_VOLTAGE    = 23'd4200000;
    localparam logic [CUR_W-1:0]  RST_STEP_CURRENT    = 22'd2400000;
    localparam logic [CUR_W-1:0]  RST_DISPLAY_CURRENT = 22'd1000000;
    localparam logic [CUR_W-1:0]  RST_DEFAULT_CURRENT = 22'd3550000;
    localparam logic [CUR_W-1:0]  RST_REDUCED_CURRENT = 22'd710000;
    localparam logic [VOLT_W-1:0] RST_NORMAL_FLOAT    = 23'd4400000;
    localparam logic [VOLT_W-1:0] RST_LIMITED_FLOAT   = 23'd4100000;

    // Zone bands in tenths of a degree: lower bound inclusive, upper exclusive.
    // The lower bound of cold and the upper bound of hot are never consulted.
    localparam logic signed [TEMP_W-1:0] ZONE_LO [NUM_ZONES] =
        '{12'sd0, 12'sd0, 12'sd200, 12'sd430, 12'sd530};
    localparam logic signed [TEMP_W-1:0] ZONE_HI [NUM_ZONES] =
        '{12'sd20, 12'sd220, 12'sd450, 12'sd550, 12'sd0};

    typedef struct packed {
        logic [VOLT_W-1:0] step_voltage;
        logic [CUR_W-1:0]  step_current;
        logic [CUR_W-1:0]  display_current;
        logic [CUR_W-1:0]  default_current;
        logic [CUR_W-1:0]  reduced_current;
        logic [VOLT_W-1:0] normal_float_voltage;
        logic [VOLT_W-1:0] limited_float_voltage;
    } cfg_t;

    typedef struct packed {
        op_t                      operation;
        logic signed [TEMP_W-1:0] temperature;
        logic                     charge_full;
        logic [VOLT_W-1:0]        voltage;
        logic                     charger_present;
        logic                     display_on;
    } item_t;

    typedef struct packed {
        logic [CUR_W-1:0]  current_limit;
        reason_t           current_reason;
        logic              current_changed;
        logic [VOLT_W-1:0] float_voltage;
        logic              float_changed;
        zone_t             thermal_zone;
        logic              wake_hold;
    } result_t;

endpackage

### sv/charge_current_governor_top.sv
// Top level of the charge-current governor: stream ports and item registers.
`timescale 1ns / 1ps
`include "assert_macros.svh"

// Charge-current governor.
// Each battery event enters on the s_ stream; operation travels in s_tuser
// and the event's fields in s_tdata. One result leaves on the m_ stream for
// every event, carrying the current limit, its reason, change flags, the float
// voltage, the thermal zone and the wake-hold request.
// An accepted item is held in an input register; in the next cycle the zone
// walk and the four-way vote minimum run on it and the state and the output
// register are written together when advance is high, which sets m_tvalid.
// One item is accepted per cycle while the output is taken.
// If the receiver stalls, the result waits in the output register and one
// more item waits in the input register; s_tready then falls until the
// output is taken.
// Configuration registers are written through cfg_wen, cfg_index and cfg_wdata;
// the user must write them only in a cycle in which no item is in flight; the block does not enforce this.
// Reset empties both registers, returns the configuration to its defaults and
// puts the zone to good with all flags clear and no limit applied yet.
module charge_current_governor_top (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       cfg_wen,
    input  logic [2:0]                 cfg_index,
    input  logic [ccg_pkg::VOLT_W-1:0] cfg_wdata,
    input  logic                       s_tvalid,
    output logic                       s_tready,
    // temperature[11:0], charge_full[12], voltage[35:13], charger_present[36],
    // display_on[37], zero[39:38]
    input  logic [39:0]                s_tdata,
    // operation[1:0]
    input  logic [1:0]                 s_tuser,
    output logic                       m_tvalid,
    input  logic                       m_tready,
    // current_limit[21:0], current_reason[23:22], current_changed[24],
    // float_voltage[47:25], float_changed[48], thermal_zone[51:49],
    // wake_hold[52], zero[55:53]
    output logic [55:0]                m_tdata
);

    ccg_pkg::cfg_t    cfg;
    ccg_pkg::item_t   in_item_reg;
    logic             in_valid_reg, in_valid_next;
    ccg_pkg::result_t out_reg;
    logic             out_valid_reg, out_valid_next;
    ccg_pkg::result_t result;
    logic             advance;
    logic             s_accept;

    ccg_cfg_regs u_cfg (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_wen   (cfg_wen),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata),
        .cfg       (cfg)
    );

    ccg_core u_core (
        .clk     (clk),
        .rst_n   (rst_n),
        .advance (advance),
        .item    (in_item_reg),
        .cfg     (cfg),
        .result  (result)
    );

    assign advance  = in_valid_reg && (!out_valid_reg || m_tready);
    assign s_tready = !in_valid_reg || advance;
    assign s_accept = s_tvalid && s_tready;

    always_comb
    begin
        in_valid_next = in_valid_reg;
        if (s_accept)
            in_valid_next = 1'b1;
        else if (advance)
            in_valid_next = 1'b0;

        out_valid_next = out_valid_reg;
        if (advance)
            out_valid_next = 1'b1;
        else if (m_tready)
            out_valid_next = 1'b0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            in_valid_reg  <= in_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s_accept)
        begin
            in_item_reg.operation       <= ccg_pkg::op_t'(s_tuser);
            in_item_reg.temperature     <= s_tdata[11:0];
            in_item_reg.charge_full     <= s_tdata[12];
            in_item_reg.voltage         <= s_tdata[35:13];
            in_item_reg.charger_present <= s_tdata[36];
            in_item_reg.display_on      <= s_tdata[37];
        end
        if (advance)
            out_reg <= result;
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {3'b000, out_reg.wake_hold, out_reg.thermal_zone,
                       out_reg.float_changed, out_reg.float_voltage,
                       out_reg.current_changed, out_reg.current_reason,
                       out_reg.current_limit};

    `ASSERT_NEXT(a_advance_fills_output, clk, rst_n, advance, out_valid_reg)
    `ASSERT_ALWAYS(a_zone_in_range, clk, rst_n,
        !out_valid_reg || out_reg.thermal_zone <= ccg_pkg::ZONE_HOT)
    `ASSERT_ALWAYS(a_thermal_reason_zone, clk, rst_n,
        !out_valid_reg || out_reg.current_reason != ccg_pkg::REASON_THERMAL ||
        out_reg.thermal_zone != ccg_pkg::ZONE_GOOD)
    `ASSERT_ALWAYS(a_limit_below_default, clk, rst_n,
        !advance || result.current_limit <= cfg.default_current)

endmodule

### sv/ccg_cfg_regs.sv
// Configuration register file of the charge-current governor.
`timescale 1ns / 1ps

module ccg_cfg_regs (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       cfg_wen,
    input  logic [2:0]                 cfg_index,
    input  logic [ccg_pkg::VOLT_W-1:0] cfg_wdata,
    output ccg_pkg::cfg_t              cfg
);

    ccg_pkg::cfg_t cfg_reg;
    ccg_pkg::cfg_t cfg_next;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_wen)
        begin
            case (cfg_index)
                ccg_pkg::CFG_STEP_VOLTAGE:    cfg_next.step_voltage = cfg_wdata;
                ccg_pkg::CFG_STEP_CURRENT:
                    cfg_next.step_current = cfg_wdata[ccg_pkg::CUR_W-1:0];
                ccg_pkg::CFG_DISPLAY_CURRENT:
                    cfg_next.display_current = cfg_wdata[ccg_pkg::CUR_W-1:0];
                ccg_pkg::CFG_DEFAULT_CURRENT:
                    cfg_next.default_current = cfg_wdata[ccg_pkg::CUR_W-1:0];
                ccg_pkg::CFG_REDUCED_CURRENT:
                    cfg_next.reduced_current = cfg_wdata[ccg_pkg::CUR_W-1:0];
                ccg_pkg::CFG_NORMAL_FLOAT:    cfg_next.normal_float_voltage = cfg_wdata;
                ccg_pkg::CFG_LIMITED_FLOAT:   cfg_next.limited_float_voltage = cfg_wdata;
                default:                      cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.step_voltage          <= ccg_pkg::RST_STEP_VOLTAGE;
            cfg_reg.step_current          <= ccg_pkg::RST_STEP_CURRENT;
            cfg_reg.display_current       <= ccg_pkg::RST_DISPLAY_CURRENT;
            cfg_reg.default_current       <= ccg_pkg::RST_DEFAULT_CURRENT;
            cfg_reg.reduced_current       <= ccg_pkg::RST_REDUCED_CURRENT;
            cfg_reg.normal_float_voltage  <= ccg_pkg::RST_NORMAL_FLOAT;
            cfg_reg.limited_float_voltage <= ccg_pkg::RST_LIMITED_FLOAT;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    assign cfg = cfg_reg;

endmodule

### sv/ccg_core.sv
// Governor state, zone walk and current-vote selection for one item.
`timescale 1ns / 1ps

module ccg_core (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             advance,
    input  ccg_pkg::item_t   item,
    input  ccg_pkg::cfg_t    cfg,
    output ccg_pkg::result_t result
);

    ccg_pkg::zone_t            zone_reg, zone_next;
    logic                      step_reg, step_next;
    logic                      display_reg, display_next;
    logic                      present_reg, present_next;
    logic                      full_reg, full_next;
    logic [ccg_pkg::CUR_W-1:0] applied_reg;
    logic                      applied_valid_reg;

    ccg_pkg::zone_t            walk;
    logic                      walk_done;
    logic [ccg_pkg::CUR_W-1:0] lim;
    logic [ccg_pkg::CUR_W-1:0] thermal_vote;
    ccg_pkg::reason_t          reason;
    logic                      float_chg;

    // The zone moves one band per step towards the temperature; five steps
    // cover any distance between the outermost zones.
    always_comb
    begin
        walk      = zone_reg;
        walk_done = 1'b0;
        for (int i = 0; i < ccg_pkg::NUM_ZONES; i++)
        begin
            if (!walk_done)
            begin
                if (walk != ccg_pkg::ZONE_COLD && item.temperature < ccg_pkg::ZONE_LO[walk])
                    walk = ccg_pkg::zone_t'(walk - 3'd1);
                else if (walk != ccg_pkg::ZONE_HOT &&
                         item.temperature >= ccg_pkg::ZONE_HI[walk])
                    walk = ccg_pkg::zone_t'(walk + 3'd1);
                else
                    walk_done = 1'b1;
            end
        end
    end

    always_comb
    begin
        zone_next    = zone_reg;
        step_next    = step_reg;
        display_next = display_reg;
        present_next = present_reg;
        full_next    = full_reg;
        case (item.operation)
            ccg_pkg::OP_BATTERY:
            begin
                full_next = item.charge_full;
                zone_next = walk;
            end
            ccg_pkg::OP_VOLTAGE:
            begin
                if (!present_reg)
                    step_next = 1'b0;
                else if (item.voltage >= cfg.step_voltage)
                    step_next = 1'b1;
            end
            ccg_pkg::OP_CHARGER:
            begin
                present_next = item.charger_present;
                if (!item.charger_present)
                    step_next = 1'b0;
            end
            ccg_pkg::OP_DISPLAY:
            begin
                display_next = item.display_on;
            end
            default:
            begin
                zone_next = zone_reg;
            end
        endcase
    end

    assign float_chg = (zone_reg >= ccg_pkg::ZONE_WARM) != (zone_next >= ccg_pkg::ZONE_WARM);

    // Cold and hot stop charging outright; cool and warm reduce it.
    assign thermal_vote = (zone_next == ccg_pkg::ZONE_COLD || zone_next == ccg_pkg::ZONE_HOT) ?
                          '0 : cfg.reduced_current;

    // Strict less-than at each stage keeps ties with the lower reason.
    always_comb
    begin
        lim    = cfg.default_current;
        reason = ccg_pkg::REASON_DEFAULT;
        if (display_next && cfg.display_current < lim)
        begin
            lim    = cfg.display_current;
            reason = ccg_pkg::REASON_DISPLAY;
        end
        if (step_next && cfg.step_current < lim)
        begin
            lim    = cfg.step_current;
            reason = ccg_pkg::REASON_STEP;
        end
        if (zone_next != ccg_pkg::ZONE_GOOD && thermal_vote < lim)
        begin
            lim    = thermal_vote;
            reason = ccg_pkg::REASON_THERMAL;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            zone_reg          <= ccg_pkg::ZONE_GOOD;
            step_reg          <= 1'b0;
            display_reg       <= 1'b0;
            present_reg       <= 1'b0;
            full_reg          <= 1'b0;
            applied_reg       <= '0;
            applied_valid_reg <= 1'b0;
        end
        else if (advance)
        begin
            zone_reg          <= zone_next;
            step_reg          <= step_next;
            display_reg       <= display_next;
            present_reg       <= present_next;
            full_reg          <= full_next;
            applied_reg       <= lim;
            applied_valid_reg <= 1'b1;
        end
    end

    always_comb
    begin
        result.current_limit   = lim;
        result.current_reason  = reason;
        result.current_changed = !applied_valid_reg || (lim != applied_reg);
        result.float_voltage   = (zone_next >= ccg_pkg::ZONE_WARM) ?
                                 cfg.limited_float_voltage : cfg.normal_float_voltage;
        result.float_changed   = float_chg;
        result.thermal_zone    = zone_next;
        result.wake_hold       = present_next && !full_next;
    end

endmodule
